// ----- rtl/core/mdpp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdpp_pkg
// Shared types, constants and the pixel packing function of the mipmap
// downsampler.
// ----------------------------------------------------------------------------
package mdpp_pkg;

   localparam int PIXEL_W     = 32;
   localparam int ROW_W       = 12;
   localparam int OY_W        = 11;
   localparam int PX_W        = 6;
   localparam int STEP_W      = 7;
   localparam int LS_ADDR_W   = 13;
   localparam int DIV_STEPS   = 12;
   localparam int DIV_CNT_W   = 4;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 13;

   localparam logic [PIXEL_W-1:0] QUARTER_MASK = 32'hfcfcfcfc;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SRC_WIDTH  = 3'd0,
      CSR_SRC_HEIGHT = 3'd1,
      CSR_DST_WIDTH  = 3'd2,
      CSR_DST_HEIGHT = 3'd3,
      CSR_STEP_X     = 3'd4,
      CSR_STEP_Y     = 3'd5,
      CSR_OUT_FORMAT = 3'd6,
      CSR_DS_ENABLE  = 3'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      FMT_8888 = 3'd0,
      FMT_1555 = 3'd1,
      FMT_4444 = 3'd2,
      FMT_8332 = 3'd3,
      FMT_565  = 3'd4
   } fmt_type;

   typedef enum logic [1:0] {
      OP_PASS  = 2'd0,
      OP_WRITE = 2'd1,
      OP_EMIT  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      FS_RUN    = 2'd0,
      FS_LOAD   = 2'd1,
      FS_DIVIDE = 2'd2
   } front_state_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               first_of_image;
   } req_word_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] out_pixel;
      logic               last_of_image;
   } rsp_word_type;

   typedef struct packed {
      logic [12:0] src_width;
      logic [12:0] src_height;
      logic [10:0] dst_width;
      logic [11:0] dst_height;
      logic [6:0]  step_x;
      logic [6:0]  step_y;
      logic [2:0]  out_format;
      logic        downsample_enable;
   } cfg_type;

   typedef struct packed {
      op_type               op;
      logic [LS_ADDR_W-1:0] addr;
      logic [PIXEL_W-1:0]   data;
      logic                 last;
   } op_word_type;

   function automatic logic [PIXEL_W-1:0] pack_pixel(logic [2:0] fmt,
                                                     logic [PIXEL_W-1:0] p);
      logic [PIXEL_W-1:0] r;
      unique case (fmt)
         FMT_1555: r = {16'h0000, p[31], p[23:19], p[15:11], p[7:3]};
         FMT_4444: r = {16'h0000, p[31:28], p[23:20], p[15:12], p[7:4]};
         FMT_8332: r = {16'h0000, p[31:24], p[23:21], p[15:13], p[7:6]};
         FMT_565:  r = {16'h0000, p[23:19], p[15:10], p[7:3]};
         default:  r = p;
      endcase
      return r;
   endfunction

endpackage

// ----- rtl/core/mdpp_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdpp_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module mdpp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/mdpp_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdpp_queue
// Short operation queue between the classifying front and the back end.
// ----------------------------------------------------------------------------
module mdpp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  mdpp_pkg::op_word_type push_word,
   output logic                 full,
   input  logic                 pop,
   output logic                 head_valid,
   output mdpp_pkg::op_word_type head_word
);

   mdpp_pkg::op_word_type       word_ff [mdpp_pkg::QUEUE_DEPTH];
   logic [mdpp_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [mdpp_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [mdpp_pkg::QCNT_W-1:0] count_ff, count_in;
   logic                        do_push;
   logic                        do_pop;

   assign full       = (count_ff == mdpp_pkg::QCNT_W'(mdpp_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_word  = word_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         word_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

// ----- rtl/core/mdpp_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdpp_front
// Accepts source words, tracks the source position and its grid cell, and
// classifies each pixel: line store write, emit, passthrough, hold or drop.
// ----------------------------------------------------------------------------
module mdpp_front #(
   parameter int MAX_DST_WIDTH = 1024,
   parameter int MAX_SRC_WIDTH = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mdpp_pkg::cfg_type     cfg,
   input  logic                  cfg_wr,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  mdpp_pkg::req_word_type req_word,
   input  logic                  q_full,
   output logic                  push,
   output mdpp_pkg::op_word_type push_word
);

   localparam int SW_MAX = (MAX_SRC_WIDTH < 4096) ? MAX_SRC_WIDTH : 4096;
   localparam int COL_W  = $clog2(SW_MAX);
   localparam int CMP_W  = 16;
   localparam int ROW_W  = mdpp_pkg::ROW_W;
   localparam int OY_W   = mdpp_pkg::OY_W;
   localparam int PX_W   = mdpp_pkg::PX_W;
   localparam int STEP_W = mdpp_pkg::STEP_W;

   mdpp_pkg::front_state_type state_ff, state_in;

   logic [COL_W-1:0]              col_ff, col_in;
   logic [ROW_W-1:0]              row_ff, row_in;
   logic [PX_W-1:0]               px_ff, px_in;
   logic [COL_W-1:0]              ox_ff, ox_in;
   logic [PX_W-1:0]               py_ff, py_in;
   logic [OY_W-1:0]               oy_ff, oy_in;
   logic [mdpp_pkg::PIXEL_W-1:0]  left_ff, left_in;
   logic [mdpp_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [ROW_W-1:0]              dvd_c_ff, dvd_c_in;
   logic [ROW_W-1:0]              dvd_r_ff, dvd_r_in;
   logic [PX_W-1:0]               rem_c_ff, rem_c_in;
   logic [PX_W-1:0]               rem_r_ff, rem_r_in;

   logic [COL_W-1:0]  last_col;
   logic [ROW_W-1:0]  last_row;
   logic [CMP_W-1:0]  last_ox;
   logic [OY_W-1:0]   last_oy;
   logic [STEP_W-1:0] sx;
   logic [STEP_W-1:0] sy;

   logic              accept;
   logic [COL_W-1:0]  c;
   logic [ROW_W-1:0]  r;
   logic [PX_W-1:0]   px;
   logic [COL_W-1:0]  ox;
   logic [PX_W-1:0]   py;
   logic [OY_W-1:0]   oy;
   logic [mdpp_pkg::PIXEL_W-1:0] q;
   logic [mdpp_pkg::PIXEL_W-1:0] pair;
   logic              in_win;

   logic [STEP_W-1:0] rt_c, rt_r;
   logic              ge_c, ge_r;
   logic [PX_W-1:0]   rem_c_nx, rem_r_nx;
   logic [ROW_W-1:0]  dvd_c_nx, dvd_r_nx;

   // clamped register values
   always_comb begin
      if (cfg.src_width == '0) begin
         last_col = '0;
      end else if (32'(cfg.src_width) > SW_MAX) begin
         last_col = COL_W'(SW_MAX - 1);
      end else begin
         last_col = COL_W'(cfg.src_width - 13'd1);
      end
      if (cfg.src_height == '0) begin
         last_row = '0;
      end else if (cfg.src_height > 13'd4096) begin
         last_row = ROW_W'(4095);
      end else begin
         last_row = ROW_W'(cfg.src_height - 13'd1);
      end
      if (cfg.dst_width == '0) begin
         last_ox = '0;
      end else if (32'(cfg.dst_width) > MAX_DST_WIDTH) begin
         last_ox = CMP_W'(MAX_DST_WIDTH - 1);
      end else begin
         last_ox = CMP_W'(cfg.dst_width - 11'd1);
      end
      if (cfg.dst_height == '0) begin
         last_oy = '0;
      end else if (cfg.dst_height > 12'd2048) begin
         last_oy = OY_W'(2047);
      end else begin
         last_oy = OY_W'(cfg.dst_height - 12'd1);
      end
      if (cfg.step_x < 7'd2) begin
         sx = 7'd2;
      end else if (cfg.step_x > 7'd64) begin
         sx = 7'd64;
      end else begin
         sx = cfg.step_x;
      end
      if (cfg.step_y < 7'd2) begin
         sy = 7'd2;
      end else if (cfg.step_y > 7'd64) begin
         sy = 7'd64;
      end else begin
         sy = cfg.step_y;
      end
   end

   assign req_stall = (state_ff != mdpp_pkg::FS_RUN) || q_full;
   assign accept    = req_valid && !req_stall;

   // position of this word
   assign c  = req_word.first_of_image ? '0 : col_ff;
   assign r  = req_word.first_of_image ? '0 : row_ff;
   assign px = req_word.first_of_image ? '0 : px_ff;
   assign ox = req_word.first_of_image ? '0 : ox_ff;
   assign py = req_word.first_of_image ? '0 : py_ff;
   assign oy = req_word.first_of_image ? '0 : oy_ff;

   assign q      = (req_word.pixel & mdpp_pkg::QUARTER_MASK) >> 2;
   assign pair   = left_ff + q;
   assign in_win = (CMP_W'(ox) <= last_ox) && (oy <= last_oy) &&
                   (px <= PX_W'(1)) && (py <= PX_W'(1));

   // one restoring division step on column and row
   assign rt_c     = {rem_c_ff, dvd_c_ff[ROW_W-1]};
   assign rt_r     = {rem_r_ff, dvd_r_ff[ROW_W-1]};
   assign ge_c     = (rt_c >= sx);
   assign ge_r     = (rt_r >= sy);
   assign rem_c_nx = ge_c ? PX_W'(rt_c - sx) : PX_W'(rt_c);
   assign rem_r_nx = ge_r ? PX_W'(rt_r - sy) : PX_W'(rt_r);
   assign dvd_c_nx = {dvd_c_ff[ROW_W-2:0], ge_c};
   assign dvd_r_nx = {dvd_r_ff[ROW_W-2:0], ge_r};

   always_comb begin
      state_in  = state_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      px_in     = px_ff;
      ox_in     = ox_ff;
      py_in     = py_ff;
      oy_in     = oy_ff;
      left_in   = left_ff;
      cnt_in    = cnt_ff;
      dvd_c_in  = dvd_c_ff;
      dvd_r_in  = dvd_r_ff;
      rem_c_in  = rem_c_ff;
      rem_r_in  = rem_r_ff;
      push      = 1'b0;
      push_word = '{op: mdpp_pkg::OP_PASS, addr: mdpp_pkg::LS_ADDR_W'(ox),
                    data: pair, last: 1'b0};

      unique case (state_ff)
         mdpp_pkg::FS_RUN: begin
            if (accept) begin
               if (!cfg.downsample_enable) begin
                  push           = 1'b1;
                  push_word.op   = mdpp_pkg::OP_PASS;
                  push_word.data = req_word.pixel;
                  push_word.last = (c == last_col) && (r == last_row);
               end else if (in_win) begin
                  if (px == '0) begin
                     left_in = q;
                  end else if (py == '0) begin
                     push         = 1'b1;
                     push_word.op = mdpp_pkg::OP_WRITE;
                  end else begin
                     push           = 1'b1;
                     push_word.op   = mdpp_pkg::OP_EMIT;
                     push_word.last = (CMP_W'(ox) == last_ox) && (oy == last_oy);
                  end
               end
               if (c == last_col) begin
                  col_in = '0;
                  px_in  = '0;
                  ox_in  = '0;
                  if (r == last_row) begin
                     row_in = '0;
                     py_in  = '0;
                     oy_in  = '0;
                  end else begin
                     row_in = r + 1'b1;
                     if ({1'b0, py} + 1'b1 == sy) begin
                        py_in = '0;
                        oy_in = oy + 1'b1;
                     end else begin
                        py_in = py + 1'b1;
                        oy_in = oy;
                     end
                  end
               end else begin
                  col_in = c + 1'b1;
                  row_in = r;
                  py_in  = py;
                  oy_in  = oy;
                  if ({1'b0, px} + 1'b1 == sx) begin
                     px_in = '0;
                     ox_in = ox + 1'b1;
                  end else begin
                     px_in = px + 1'b1;
                     ox_in = ox;
                  end
               end
            end
         end
         mdpp_pkg::FS_LOAD: begin
            col_in   = (col_ff > last_col) ? last_col : col_ff;
            row_in   = (row_ff > last_row) ? last_row : row_ff;
            dvd_c_in = ROW_W'(col_in);
            dvd_r_in = row_in;
            rem_c_in = '0;
            rem_r_in = '0;
            cnt_in   = '0;
            state_in = mdpp_pkg::FS_DIVIDE;
         end
         mdpp_pkg::FS_DIVIDE: begin
            dvd_c_in = dvd_c_nx;
            dvd_r_in = dvd_r_nx;
            rem_c_in = rem_c_nx;
            rem_r_in = rem_r_nx;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == mdpp_pkg::DIV_CNT_W'(mdpp_pkg::DIV_STEPS - 1)) begin
               px_in    = rem_c_nx;
               ox_in    = COL_W'(dvd_c_nx);
               py_in    = rem_r_nx;
               oy_in    = OY_W'(dvd_r_nx);
               state_in = mdpp_pkg::FS_RUN;
            end
         end
         default: begin
            state_in = mdpp_pkg::FS_RUN;
         end
      endcase

      if (cfg_wr) begin
         state_in = mdpp_pkg::FS_LOAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mdpp_pkg::FS_RUN;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         px_ff   <= '0;
         ox_ff   <= '0;
         py_ff   <= '0;
         oy_ff   <= '0;
         left_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         px_ff   <= px_in;
         ox_ff   <= ox_in;
         py_ff   <= py_in;
         oy_ff   <= oy_in;
         left_ff <= left_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_c_ff <= dvd_c_in;
      dvd_r_ff <= dvd_r_in;
      rem_c_ff <= rem_c_in;
      rem_r_ff <= rem_r_in;
   end

endmodule

// ----- rtl/core/mdpp_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdpp_back
// Executes queued operations: line store writes, line store reads with the
// final 2x2 sum, packing and the output register.
// ----------------------------------------------------------------------------
module mdpp_back #(
   parameter int MAX_DST_WIDTH = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [2:0]            out_format,
   input  logic                  head_valid,
   input  mdpp_pkg::op_word_type head_word,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output mdpp_pkg::rsp_word_type rsp_word
);

   localparam int AW = $clog2(MAX_DST_WIDTH);

   logic                          s2_valid_ff, s2_valid_in;
   logic                          s2_emit_ff, s2_emit_in;
   logic [mdpp_pkg::PIXEL_W-1:0]  s2_data_ff, s2_data_in;
   logic                          s2_last_ff, s2_last_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   mdpp_pkg::rsp_word_type        rsp_word_ff, rsp_word_in;

   logic                          out_adv;
   logic                          s2_free;
   logic                          ram_wr;
   logic                          ram_rd;
   logic [mdpp_pkg::PIXEL_W-1:0]  upper_sum;
   logic [mdpp_pkg::PIXEL_W-1:0]  total;

   assign out_adv = !rsp_valid_ff || !rsp_stall;
   assign s2_free = !s2_valid_ff || out_adv;
   assign pop     = head_valid && s2_free;
   assign ram_wr  = pop && (head_word.op == mdpp_pkg::OP_WRITE);
   assign ram_rd  = pop && (head_word.op == mdpp_pkg::OP_EMIT);

   mdpp_ram #(
      .WIDTH (mdpp_pkg::PIXEL_W),
      .DEPTH (MAX_DST_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (ram_wr),
      .rd_en   (ram_rd),
      .addr    (head_word.addr[AW-1:0]),
      .wr_data (head_word.data),
      .rd_data (upper_sum)
   );

   assign total = s2_emit_ff ? upper_sum + s2_data_ff : s2_data_ff;

   always_comb begin
      s2_valid_in  = s2_valid_ff;
      s2_emit_in   = s2_emit_ff;
      s2_data_in   = s2_data_ff;
      s2_last_in   = s2_last_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (s2_free) begin
         s2_valid_in = pop && (head_word.op != mdpp_pkg::OP_WRITE);
         s2_emit_in  = (head_word.op == mdpp_pkg::OP_EMIT);
         s2_data_in  = head_word.data;
         s2_last_in  = head_word.last;
      end
      if (out_adv) begin
         rsp_valid_in              = s2_valid_ff;
         rsp_word_in.out_pixel     = mdpp_pkg::pack_pixel(out_format, total);
         rsp_word_in.last_of_image = s2_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_emit_ff  <= s2_emit_in;
      s2_data_ff  <= s2_data_in;
      s2_last_ff  <= s2_last_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// ----- rtl/core/mipmap_downsample_pixel_pack.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mipmap_downsample_pixel_pack
// 2x2 box filter downsampler for ARGB8888 raster streams with output packing.
// ----------------------------------------------------------------------------
// usage
//   req_ channel: one source pixel per word, raster order, first_of_image on
//   the first pixel of an image. rsp_ channel: packed pixels, last_of_image
//   on the final output pixel. csr_ channel: register writes, always ready;
//   write only while no word is in flight.
//   throughput: one source word per cycle while req_stall is low, set by the
//   single-port line store in the back end (at most one write or read per word).
//   emits and passthroughs reach rsp_ via the queue, s2 stage and output register.
//   after each register write the input stalls through a load state and
//   a 12-step divider that re-derives the current source position's grid cell.
//   reset clears position counters, the queue and the output valid and loads
//   the register defaults; the line store is not cleared.
//   a stalled receiver holds the output word; the four-entry queue keeps the
//   input moving until it fills, then req_stall rises.
// ----------------------------------------------------------------------------
module mipmap_downsample_pixel_pack #(
   parameter int MAX_DST_WIDTH = 1024,
   parameter int MAX_SRC_WIDTH = 4096
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  mdpp_pkg::req_word_type                req_word,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output mdpp_pkg::rsp_word_type                rsp_word,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [mdpp_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [mdpp_pkg::CSR_DATA_W-1:0]       csr_data
);

   mdpp_pkg::cfg_type     cfg_ff, cfg_in;
   logic                  cfg_wr;
   logic                  q_full;
   logic                  push;
   mdpp_pkg::op_word_type push_word;
   logic                  pop;
   logic                  head_valid;
   mdpp_pkg::op_word_type head_word;

   assign csr_ready = 1'b1;
   assign cfg_wr    = csr_valid && csr_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_wr) begin
         unique case (mdpp_pkg::csr_index_type'(csr_index))
            mdpp_pkg::CSR_SRC_WIDTH:  cfg_in.src_width         = csr_data[12:0];
            mdpp_pkg::CSR_SRC_HEIGHT: cfg_in.src_height        = csr_data[12:0];
            mdpp_pkg::CSR_DST_WIDTH:  cfg_in.dst_width         = csr_data[10:0];
            mdpp_pkg::CSR_DST_HEIGHT: cfg_in.dst_height        = csr_data[11:0];
            mdpp_pkg::CSR_STEP_X:     cfg_in.step_x            = csr_data[6:0];
            mdpp_pkg::CSR_STEP_Y:     cfg_in.step_y            = csr_data[6:0];
            mdpp_pkg::CSR_OUT_FORMAT: cfg_in.out_format        = csr_data[2:0];
            mdpp_pkg::CSR_DS_ENABLE:  cfg_in.downsample_enable = csr_data[0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{src_width: 13'd256, src_height: 13'd256,
                     dst_width: 11'd128, dst_height: 12'd128,
                     step_x: 7'd2, step_y: 7'd2,
                     out_format: mdpp_pkg::FMT_8888, downsample_enable: 1'b1};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mdpp_front #(
      .MAX_DST_WIDTH (MAX_DST_WIDTH),
      .MAX_SRC_WIDTH (MAX_SRC_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cfg_wr    (cfg_wr),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .q_full    (q_full),
      .push      (push),
      .push_word (push_word)
   );

   mdpp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_word  (push_word),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_word  (head_word)
   );

   mdpp_back #(
      .MAX_DST_WIDTH (MAX_DST_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .out_format (cfg_ff.out_format),
      .head_valid (head_valid),
      .head_word  (head_word),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_word   (rsp_word)
   );

endmodule

// ----- rtl/core/mdpp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdpp_checker
// Port-level checks of the mipmap downsampler, bound to the top level.
// ----------------------------------------------------------------------------
module mdpp_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input mdpp_pkg::rsp_word_type rsp_word,
   input logic                   csr_valid,
   input logic                   csr_ready
);

   // stalled output word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("rsp word changed while stalled");

   // a register write blocks input while position is re-derived
   a_csr_blocks: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> req_stall)
      else $error("input accepted right after register write");

   // reset empties the output
   a_reset_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // reset leaves the input open
   a_reset_req: assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("req stalled after reset");

endmodule

bind mipmap_downsample_pixel_pack mdpp_checker u_mdpp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready)
);

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the mipmap downsampler with pixel packing. A queue
// of source words feeds a clocked driver, and every accepted word runs through
// a bench-side box filter and packer. A clocked monitor compares each packed
// word with the oldest prediction. Register settings change between phases
// while the block is idle. Both sides pause in random bursts.
// ----------------------------------------------------------------------------
module tb;

   localparam int unsigned MAX_DST_W     = 1024;
   localparam int unsigned SETTLE_CYCLES = 10;
   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int unsigned WORD_TARGET   = 1150;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   mdpp_pkg::req_word_type          req_word = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   mdpp_pkg::rsp_word_type          rsp_word;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   mdpp_pkg::csr_index_type         csr_index = mdpp_pkg::CSR_SRC_WIDTH;
   logic [mdpp_pkg::CSR_DATA_W-1:0] csr_data = '0;

   // bench copy of the block's registers and filter state
   mdpp_pkg::cfg_type      active_cfg;
   logic [31:0]            upper_sums [MAX_DST_W];
   logic [31:0]            left_q = '0;
   int unsigned            src_col = 0;
   int unsigned            src_row = 0;

   mdpp_pkg::req_word_type source_words [$];
   mdpp_pkg::rsp_word_type expected_pixels [$];
   mdpp_pkg::rsp_word_type wanted;

   bit                     sender_idles = 1'b1;
   bit                     receiver_idles = 1'b1;
   int unsigned            send_gap = 0;
   int unsigned            stall_left = 0;
   int unsigned            cycle_count = 0;
   int unsigned            mismatches = 0;
   int unsigned            words_queued = 0;
   int unsigned            packed_checked = 0;
   int unsigned            settings_run = 0;
   logic [31:0]            corner_pix [4];

   mipmap_downsample_pixel_pack u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   function automatic int unsigned clamp(input int unsigned v, lo, hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic logic [31:0] pack_format(input logic [2:0] fmt, input logic [31:0] p);
      case (fmt)
         mdpp_pkg::FMT_1555: return ((p >> 16) & 32'h8000) | ((p >> 9) & 32'h7c00) |
                                    ((p >> 6) & 32'h03e0) | ((p >> 3) & 32'h001f);
         mdpp_pkg::FMT_4444: return ((p >> 16) & 32'hf000) | ((p >> 12) & 32'h0f00) |
                                    ((p >> 8) & 32'h00f0) | ((p >> 4) & 32'h000f);
         mdpp_pkg::FMT_8332: return ((p >> 16) & 32'hff00) | ((p >> 16) & 32'h00e0) |
                                    ((p >> 11) & 32'h001c) | ((p >> 6) & 32'h0003);
         mdpp_pkg::FMT_565:  return ((p >> 8) & 32'hf800) | ((p >> 5) & 32'h07e0) |
                                    ((p >> 3) & 32'h001f);
         default:            return p;
      endcase
   endfunction

   function automatic void predict_pixel(input mdpp_pkg::req_word_type w);
      int unsigned sw, sh, dw, dh, sx, sy, c, r, ox, oy, px, py;
      logic [31:0] q;
      mdpp_pkg::rsp_word_type o;
      sw = clamp(active_cfg.src_width, 1, 4096);
      sh = clamp(active_cfg.src_height, 1, 4096);
      dw = clamp(active_cfg.dst_width, 1, MAX_DST_W);
      dh = clamp(active_cfg.dst_height, 1, 2048);
      sx = clamp(active_cfg.step_x, 2, 64);
      sy = clamp(active_cfg.step_y, 2, 64);
      if (w.first_of_image) begin
         src_col = 0;
         src_row = 0;
      end
      c = (src_col >= sw) ? sw - 1 : src_col;
      r = (src_row >= sh) ? sh - 1 : src_row;
      if (!active_cfg.downsample_enable) begin
         o.out_pixel     = pack_format(active_cfg.out_format, w.pixel);
         o.last_of_image = (c == sw - 1) && (r == sh - 1);
         expected_pixels.push_back(o);
      end else begin
         q  = (w.pixel & mdpp_pkg::QUARTER_MASK) >> 2;
         ox = c / sx;
         px = c % sx;
         oy = r / sy;
         py = r % sy;
         if (ox < dw && oy < dh && px <= 1 && py <= 1) begin
            if (px == 0) begin
               left_q = q;
            end else if (py == 0) begin
               upper_sums[ox] = left_q + q;
            end else begin
               o.out_pixel     = pack_format(active_cfg.out_format, upper_sums[ox] + left_q + q);
               o.last_of_image = (ox == dw - 1) && (oy == dh - 1);
               expected_pixels.push_back(o);
            end
         end
      end
      c++;
      if (c >= sw) begin
         c = 0;
         r++;
         if (r >= sh) r = 0;
      end
      src_col = c;
      src_row = r;
   endfunction

   function automatic int unsigned pick_reg(input int unsigned lo, hi, e0, e1, e2, e3);
      case ($urandom_range(0, 19))
         0: return e0;
         1: return e1;
         2: return e2;
         3: return e3;
         default: return $urandom_range(lo, hi);
      endcase
   endfunction

   task automatic write_reg(input mdpp_pkg::csr_index_type idx, input int unsigned value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[mdpp_pkg::CSR_DATA_W-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         mdpp_pkg::CSR_SRC_WIDTH:  active_cfg.src_width = value[12:0];
         mdpp_pkg::CSR_SRC_HEIGHT: active_cfg.src_height = value[12:0];
         mdpp_pkg::CSR_DST_WIDTH:  active_cfg.dst_width = value[10:0];
         mdpp_pkg::CSR_DST_HEIGHT: active_cfg.dst_height = value[11:0];
         mdpp_pkg::CSR_STEP_X:     active_cfg.step_x = value[6:0];
         mdpp_pkg::CSR_STEP_Y:     active_cfg.step_y = value[6:0];
         mdpp_pkg::CSR_OUT_FORMAT: active_cfg.out_format = value[2:0];
         mdpp_pkg::CSR_DS_ENABLE:  active_cfg.downsample_enable = value[0];
         default: ;
      endcase
   endtask

   task automatic set_config(input int unsigned sw, sh, dw, dh, sx, sy, fmt, ds);
      write_reg(mdpp_pkg::CSR_SRC_WIDTH, sw);
      write_reg(mdpp_pkg::CSR_SRC_HEIGHT, sh);
      write_reg(mdpp_pkg::CSR_DST_WIDTH, dw);
      write_reg(mdpp_pkg::CSR_DST_HEIGHT, dh);
      write_reg(mdpp_pkg::CSR_STEP_X, sx);
      write_reg(mdpp_pkg::CSR_STEP_Y, sy);
      write_reg(mdpp_pkg::CSR_OUT_FORMAT, fmt);
      write_reg(mdpp_pkg::CSR_DS_ENABLE, ds);
      settings_run++;
   endtask

   task automatic wait_drained();
      while (source_words.size() != 0 || req_valid || expected_pixels.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic push_source(input bit first);
      logic [31:0] p;
      bit          f;
      if ($urandom_range(0, 15) == 0)
         p = $urandom_range(0, 1) ? 32'hffffffff : 32'h00000000;
      else
         p = $urandom;
      f = first || ($urandom_range(0, 49) == 0);
      source_words.push_back('{pixel: p, first_of_image: f});
      words_queued++;
   endtask

   // one to three whole or cut images where they are small, else one image's head
   task automatic queue_words(input int unsigned sw, sh);
      int unsigned frame, images, n;
      frame = sw * sh;
      if (frame <= 240) begin
         images = $urandom_range(1, 3);
         for (int i = 0; i < images; i++) begin
            n = frame;
            if (frame > 1 && $urandom_range(0, 9) == 0) n = $urandom_range(1, frame - 1);
            for (int k = 0; k < n; k++) begin
               if (words_queued >= WORD_TARGET) break;
               push_source(k == 0 && (i == 0 || $urandom_range(0, 5) != 0));
            end
         end
      end else begin
         n = $urandom_range(40, 120);
         for (int k = 0; k < n; k++) begin
            if (words_queued >= WORD_TARGET) break;
            push_source(k == 0);
         end
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && !req_stall) predict_pixel(req_word);
         if (!req_valid || !req_stall) begin
            if (send_gap != 0) begin
               send_gap  <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (source_words.size() != 0) begin
               req_word  <= source_words.pop_front();
               req_valid <= 1'b1;
               if (sender_idles && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 7);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               $error("unexpected packed word: out_pixel %h last_of_image %b",
                      rsp_word.out_pixel, rsp_word.last_of_image);
               mismatches++;
            end else begin
               wanted = expected_pixels.pop_front();
               packed_checked++;
               if (rsp_word.out_pixel !== wanted.out_pixel) begin
                  $error("out_pixel: expected %h, actual %h", wanted.out_pixel, rsp_word.out_pixel);
                  mismatches++;
               end
               if (rsp_word.last_of_image !== wanted.last_of_image) begin
                  $error("last_of_image: expected %b, actual %b",
                         wanted.last_of_image, rsp_word.last_of_image);
                  mismatches++;
               end
            end
         end
         if (stall_left != 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= stall_left - 1;
         end else begin
            rsp_stall <= 1'b0;
            if (receiver_idles && $urandom_range(0, 7) == 0) stall_left <= $urandom_range(1, 7);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      int unsigned sw, sh, dw, dh, sx, sy;
      active_cfg = '{src_width: 256, src_height: 256, dst_width: 128, dst_height: 128,
                     step_x: 2, step_y: 2, out_format: mdpp_pkg::FMT_8888,
                     downsample_enable: 1'b1};
      foreach (upper_sums[i]) upper_sums[i] = '0;
      corner_pix[0] = 32'hffffffff;
      corner_pix[1] = 32'h00000000;
      corner_pix[2] = 32'haa55aa55;
      corner_pix[3] = 32'h57a8c403;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // one 2x2 window per packing
      set_config(2, 2, 1, 1, 2, 2, mdpp_pkg::FMT_8888, 1);
      for (int f = mdpp_pkg::FMT_8888; f <= mdpp_pkg::FMT_565; f++) begin
         write_reg(mdpp_pkg::CSR_OUT_FORMAT, f);
         for (int k = 0; k < 4; k++)
            source_words.push_back('{pixel: corner_pix[(k + f) % 4], first_of_image: k == 0});
         words_queued += 4;
         wait_drained();
      end

      // passthrough, unknown format code, run past the image end
      set_config(3, 1, 1, 1, 2, 2, 5, 0);
      for (int k = 0; k < 4; k++)
         source_words.push_back('{pixel: corner_pix[3 - k], first_of_image: k == 0});
      words_queued += 4;
      wait_drained();

      // saturating and boundary settings
      set_config(8191, 8191, 2047, 4095, 127, 127, 7, 1);
      queue_words(4096, 4096);
      wait_drained();
      set_config(0, 0, 0, 0, 0, 0, mdpp_pkg::FMT_565, 1);
      queue_words(1, 1);
      wait_drained();
      set_config(4096, 4096, 1024, 2048, 64, 64, mdpp_pkg::FMT_4444, 1);
      queue_words(4096, 4096);
      wait_drained();

      while (words_queued < WORD_TARGET) begin
         sender_idles   = ($urandom_range(0, 3) != 0) && (words_queued < WORD_TARGET - 200);
         receiver_idles = ($urandom_range(0, 3) != 0) && (words_queued < WORD_TARGET - 200);
         sw = pick_reg(2, 16, 0, 1, 4096, 8191);
         sh = pick_reg(2, 12, 0, 1, 4096, 8191);
         dw = pick_reg(1, 8, 0, 1, 1024, 2047);
         dh = pick_reg(1, 6, 0, 1, 2048, 4095);
         sx = pick_reg(2, 4, 0, 1, 64, 127);
         sy = pick_reg(2, 4, 0, 1, 64, 127);
         set_config(sw, sh, dw, dh, sx, sy, $urandom_range(0, 7), $urandom_range(0, 4) != 0);
         queue_words(clamp(sw, 1, 4096), clamp(sh, 1, 4096));
         wait_drained();
      end

      $display("%0d source words under %0d register settings, %0d packed words compared",
               words_queued, settings_run, packed_checked);
      $display("all packings, passthrough, saturated registers and cut windows exercised");
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
